// ===== design/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the multichannel moving average block:
// word layouts, register indexes, request codes and controller/datapath links.
// ----------------------------------------------------------------------------
package mma_pkg;

    // default sizing of the block
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_BITS  = 10;

    // fixed field widths
    localparam int REQ_W      = 1;
    localparam int CHAN_W     = 8;
    localparam int SMP_W      = 10;
    localparam int AVG_W      = 10;
    localparam int SUM_W      = 16;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CIU_W      = 5;
    localparam int WLEN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 2'd1;

    // configuration reset values
    localparam logic [CIU_W-1:0]  CIU_RESET  = 5'd16;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 1'b0;
    localparam logic [REQ_W-1:0] REQ_SEED = 1'b1;

    // input word
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAN_W-1:0] channel;
        logic [SMP_W-1:0]  sample;
    } in_item_t;

    // output word
    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic              channel_valid;
        logic [CHAN_W-1:0] channel_echo;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_old;
        logic push_wr;
        logic seed_start;
        logic seed_wr;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic item_ok;
        logic is_seed;
        logic seed_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/mma_div.sv =====
// ----------------------------------------------------------------------------
// mma_div
// Restoring divider: unsigned running sum by window length, one quotient bit
// per cycle; done pulses as the last step is registered, with the final quotient.
// ----------------------------------------------------------------------------
module mma_div #(
    parameter int DIVISOR_W = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mma_pkg::SUM_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output logic [mma_pkg::SUM_W-1:0] quotient,
    output logic                     done
);
    import mma_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [STEP_W-1:0]    cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] diff;
    logic                 borrow;

    // trial subtract of one step
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign borrow  = diff[DIVISOR_W+1];

    // iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[SUM_W-2:0], ~borrow};
                rem_reg <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== design/mma_dp.sv =====
// ----------------------------------------------------------------------------
// mma_dp
// Datapath: sample window memory, per-channel pointers and sums, item
// registers, divider and the output register.
// ----------------------------------------------------------------------------
module mma_dp #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mma_pkg::in_item_t             in_data,
    input  logic [mma_pkg::CIU_W-1:0]     channels_in_use,
    input  logic [mma_pkg::WLEN_W-1:0]    window_len,
    input  mma_pkg::dp_cmd_t              cmd,
    output mma_pkg::dp_status_t           status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mma_pkg::out_item_t            out_data
);
    import mma_pkg::*;

    localparam int DEPTH    = MAX_CHANNELS * MAX_WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
    localparam int SAT_W    = SUM_W + 1;
    localparam logic [SAT_W-1:0] SAT_LIMIT = SAT_W'((1 << SAMPLE_BITS) - 1);

    // sample window memory
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    // per-channel state
    logic [SLOT_W-1:0] wptr_reg [MAX_CHANNELS];
    logic [SUM_W-1:0]  sum_reg  [MAX_CHANNELS];

    // current item
    logic                   req_reg;
    logic [CHAN_W-1:0]      ch_reg;
    logic [CH_IDX_W-1:0]    ch_idx_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [SLOT_W-1:0]      ptr_reg;
    logic                   ok_reg;

    // sweeps and results
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       res_sum_reg;

    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    // accept-time decode
    logic [CHAN_W-1:0]      wl_ext;
    logic [LEN_W-1:0]       len_in;
    logic                   ok_in;
    logic [CH_IDX_W-1:0]    ch_idx_in;
    logic [SLOT_W-1:0]      wptr_rd;
    logic [SLOT_W-1:0]      ptr_in;

    // address and arithmetic
    logic [ADDR_W-1:0]      base_addr;
    logic [SLOT_W-1:0]      wr_slot;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [LEN_W-1:0]       ptr_inc;
    logic [SLOT_W-1:0]      ptr_adv;
    logic [LEN_W-1:0]       slot_inc;
    logic [SUM_W-1:0]       push_sum;
    logic [SUM_W-1:0]       seed_sum;
    logic [SUM_W-1:0]       quotient;
    logic                   div_done;
    logic [SAT_W-1:0]       avg_sat;

    // effective window length and channel check
    assign wl_ext    = CHAN_W'(window_len);
    assign len_in    = (window_len == '0) ? LEN_W'(1) :
                       (wl_ext > CHAN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) :
                       LEN_W'(window_len);
    assign ok_in     = (in_data.channel < CHAN_W'(channels_in_use)) &&
                       (in_data.channel < CHAN_W'(MAX_CHANNELS));
    assign ch_idx_in = in_data.channel[CH_IDX_W-1:0];
    assign wptr_rd   = ok_in ? wptr_reg[ch_idx_in] : '0;
    assign ptr_in    = (LEN_W'(wptr_rd) >= len_in) ? '0 : wptr_rd;

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg    <= in_data.req_type;
            ch_reg     <= in_data.channel;
            ch_idx_reg <= ch_idx_in;
            smp_reg    <= SAMPLE_BITS'(in_data.sample);
            len_reg    <= len_in;
            ptr_reg    <= ptr_in;
            ok_reg     <= ok_in;
        end
    end

    // memory addressing
    assign base_addr = ADDR_W'(ch_idx_reg) * ADDR_W'(MAX_WINDOW);
    assign wr_slot   = cmd.push_wr ? ptr_reg : slot_reg;
    assign wr_addr   = cmd.clr_wr ? clr_cnt_reg : base_addr + ADDR_W'(wr_slot);
    assign rd_addr   = base_addr + ADDR_W'(ptr_reg);
    assign mem_we    = cmd.clr_wr | cmd.push_wr | cmd.seed_wr;
    assign mem_wdata = cmd.clr_wr ? '0 : smp_reg;

    // window memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= mem_wdata;
        end
        if (cmd.rd_old)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // pointer advance and sums
    assign ptr_inc  = LEN_W'(ptr_reg) + 1'b1;
    assign ptr_adv  = (ptr_inc == len_reg) ? '0 : SLOT_W'(ptr_inc);
    assign slot_inc = LEN_W'(slot_reg) + 1'b1;
    assign push_sum = sum_reg[ch_idx_reg] - SUM_W'(rdata_reg) + SUM_W'(smp_reg);
    assign seed_sum = acc_reg + SUM_W'(smp_reg);

    // per-channel state, clear sweep and seed sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                wptr_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
            clr_cnt_reg <= '0;
            slot_reg    <= '0;
            acc_reg     <= '0;
            res_sum_reg <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.push_wr)
            begin
                wptr_reg[ch_idx_reg] <= ptr_adv;
                sum_reg[ch_idx_reg]  <= push_sum;
                res_sum_reg          <= push_sum;
            end
            if (cmd.seed_start)
            begin
                slot_reg <= '0;
                acc_reg  <= '0;
            end
            if (cmd.seed_wr)
            begin
                slot_reg <= SLOT_W'(slot_inc);
                acc_reg  <= seed_sum;
                if (status.seed_last)
                begin
                    wptr_reg[ch_idx_reg] <= ptr_reg;
                    sum_reg[ch_idx_reg]  <= seed_sum;
                    res_sum_reg          <= seed_sum;
                end
            end
        end
    end

    // average divider
    mma_div #(
        .DIVISOR_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (res_sum_reg),
        .divisor  (len_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // saturate to the sample range
    assign avg_sat = ({1'b0, quotient} > SAT_LIMIT) ? SAT_LIMIT : {1'b0, quotient};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.average       <= ok_reg ? AVG_W'(avg_sat) : '0;
            out_data_reg.channel_valid <= ok_reg;
            out_data_reg.channel_echo  <= ch_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to the controller
    assign status.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.item_ok   = ok_reg;
    assign status.is_seed   = (req_reg == REQ_SEED);
    assign status.seed_last = (slot_inc == len_reg);
    assign status.div_done  = div_done;
    assign status.out_free  = ~out_valid_reg | out_ready;

endmodule

// ===== design/mma_ctrl.sv =====
// ----------------------------------------------------------------------------
// mma_ctrl
// Controller: clears the window memory after reset, then steps each accepted
// word through read-modify-write or seed sweep and divide if active, then output load.
// ----------------------------------------------------------------------------
module mma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mma_pkg::dp_status_t  status,
    output mma_pkg::dp_cmd_t     cmd
);
    import mma_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DECODE   = 3'd2;
    localparam logic [2:0] ST_PUSH     = 3'd3;
    localparam logic [2:0] ST_SEED     = 3'd4;
    localparam logic [2:0] ST_DIV_GO   = 3'd5;
    localparam logic [2:0] ST_DIV_WAIT = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.item_ok)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.is_seed)
                begin
                    cmd.seed_start = 1'b1;
                    state_next     = ST_SEED;
                end
                else
                begin
                    cmd.rd_old = 1'b1;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push_wr = 1'b1;
                state_next  = ST_DIV_GO;
            end
            ST_SEED:
            begin
                cmd.seed_wr = 1'b1;
                if (status.seed_last)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel boxcar moving average over a converter sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one word: request type (push or seed), channel
//   and sample. out_valid/out_ready return one word per input word: the
//   window average, a channel valid flag and the channel echo.
//   cfg_valid/cfg_ready (always ready) write channels_in_use (index 0) and
//   window_len (index 1); write them only while the block is idle.
// Sequencing:
//   one word at a time; the next word can be accepted in the cycle after the
//   output load. A push steps through decode, memory read, write back and the
//   16-step divider before output load; a seed steps through decode, one memory
//   write per slot of the window and the divider. A word on an inactive
//   channel goes from decode straight to output load.
// Reset:
//   pointers, sums and configuration reset at once; the window memory is
//   then cleared one entry per cycle, MAX_CHANNELS * MAX_WINDOW entries
//   (1024 by default), with in_ready low. Configuration writes still go.
// Stall:
//   a finished word waits in the finish state until the output register
//   frees; no new word is accepted until its result is loaded.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
    parameter int MAX_CHANNELS = mma_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = mma_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS  = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mma_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mma_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mma_pkg::*;

    logic [CIU_W-1:0]  ciu_reg;
    logic [WLEN_W-1:0] wlen_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ciu_reg  <= CIU_RESET;
            wlen_reg <= WLEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHANNELS_IN_USE: ciu_reg  <= cfg_data[CIU_W-1:0];
                REG_WINDOW_LEN:      wlen_reg <= cfg_data[WLEN_W-1:0];
                default:             ;
            endcase
        end
    end

    // controller
    mma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    mma_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_data         (in_data),
        .channels_in_use (ciu_reg),
        .window_len      (wlen_reg),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

`ifndef SYNTHESIS
    // one word in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while previous word in flight");

    // memory clear never overlaps input accept
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !in_ready)
        else $error("input ready during memory clear");

    // only one writer of the window memory per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.push_wr, cmd.seed_wr}))
        else $error("conflicting window memory writes");

    // rejected channel always reports zero average
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.channel_valid |-> out_data.average == '0)
        else $error("nonzero average on rejected channel");
`endif

endmodule

// ===== bench/moving_average_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_average_checker
// Watches the input, output and register channels of the moving average
// block, predicts every output word from its own copy of the channel windows,
// pointers, sums and settings, and compares each returned word in order.
// ----------------------------------------------------------------------------
module moving_average_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  mma_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  mma_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import mma_pkg::*;

    localparam int PTR_W       = $clog2(DEF_MAX_WINDOW);
    localparam int AVG_CEILING = (1 << DEF_SAMPLE_BITS) - 1;
    localparam int MAX_REPORTS = 10;

    // per-channel window contents, slot pointers and running sums
    logic [SMP_W-1:0] window_mem [DEF_MAX_CHANNELS][DEF_MAX_WINDOW];
    logic [PTR_W-1:0] slot_ptr   [DEF_MAX_CHANNELS];
    logic [SUM_W-1:0] window_sum [DEF_MAX_CHANNELS];
    logic [CIU_W-1:0] chans_cfg;
    logic [WLEN_W-1:0] wlen_cfg;

    // averages still owed by the block, oldest first
    out_item_t expected_averages[$];

    // update the channel state for one word and return the average it yields
    function automatic out_item_t predict_average(in_item_t w);
        out_item_t r;
        int len;
        int chans;
        int ch;
        int slot;
        int quot;
        int s;
        r.average       = '0;
        r.channel_valid = 1'b0;
        r.channel_echo  = w.channel;
        chans = (chans_cfg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chans_cfg;
        if (wlen_cfg == 0)
            len = 1;
        else
            len = (wlen_cfg > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : wlen_cfg;
        ch = w.channel;
        if (ch >= chans)
            return r;

        // pointer left past the end by a shorter window restarts at slot 0
        slot = slot_ptr[ch];
        if (slot >= len)
            slot = 0;

        if (w.req_type == REQ_PUSH)
        begin
            window_sum[ch] = window_sum[ch] - window_mem[ch][slot] + w.sample;
            window_mem[ch][slot] = w.sample;
            slot = (slot + 1 == len) ? 0 : slot + 1;
        end
        else
        begin
            for (s = 0; s < len; s++)
                window_mem[ch][s] = w.sample;
            window_sum[ch] = SUM_W'(w.sample * len);
        end
        slot_ptr[ch] = PTR_W'(slot);

        // sum may drift after a length change, so clamp the quotient
        quot = window_sum[ch] / len;
        if (quot > AVG_CEILING)
            quot = AVG_CEILING;
        r.average       = AVG_W'(quot);
        r.channel_valid = 1'b1;
        return r;
    endfunction

    // count a failure, print only the first few
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // track register writes, predict on accept, compare on return
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        int c;
        int s;
        if (!rst_n)
        begin
            for (c = 0; c < DEF_MAX_CHANNELS; c++)
            begin
                for (s = 0; s < DEF_MAX_WINDOW; s++)
                    window_mem[c][s] = '0;
                slot_ptr[c]   = '0;
                window_sum[c] = '0;
            end
            chans_cfg = CIU_RESET;
            wlen_cfg  = WLEN_RESET;
            expected_averages.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CHANNELS_IN_USE)
                    chans_cfg = cfg_data[CIU_W-1:0];
                else if (cfg_index == REG_WINDOW_LEN)
                    wlen_cfg = cfg_data[WLEN_W-1:0];
            end

            if (in_valid && in_ready)
                expected_averages.push_back(predict_average(in_data));

            if (out_valid && out_ready)
            begin
                if (expected_averages.size() == 0)
                    note_failure($sformatf(
                        "unexpected word: avg %0d valid %0b echo %0d",
                        out_data.average, out_data.channel_valid,
                        out_data.channel_echo));
                else
                begin
                    want = expected_averages.pop_front();
                    if (out_data.average !== want.average ||
                        out_data.channel_valid !== want.channel_valid ||
                        out_data.channel_echo !== want.channel_echo)
                        note_failure($sformatf(
                            {"mismatch: expected avg %0d valid %0b echo %0d,",
                             " got avg %0d valid %0b echo %0d"},
                            want.average, want.channel_valid, want.channel_echo,
                            out_data.average, out_data.channel_valid,
                            out_data.channel_echo));
                end
            end
            outstanding <= expected_averages.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multichannel moving average: a directed pass over field
// extremes, rejected channels, stale pointers and sum wrap, then random
// pushes and seeds under changing settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import mma_pkg::*;

    localparam int RUN_LIMIT   = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 120;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 105;
    localparam int SMP_MAX     = (1 << SMP_W) - 1;

    // register indexes the block does not use
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;

    bit idle_on;
    int holds_asked;
    int holds_done;
    int eff_chans;

    multichannel_moving_average i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    moving_average_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int n;
        n = 0;
        while (n < RUN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // output side: random stall bursts and requested long hold-offs
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        holds_done = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one word, with an occasional gap before it
    task automatic send_word(input logic [REQ_W-1:0] req,
                             input logic [CHAN_W-1:0] ch,
                             input logic [SMP_W-1:0] smp);
        in_item_t w;
        w.req_type = req;
        w.channel  = ch;
        w.sample   = smp;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // one register write, valid left high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // stop offering and wait until every average is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // write both settings; spare bits of the channel count are random
    task automatic apply_config(input int chans, input int wlen, input bit spare);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(chans % 32) | CFG_DATA_W'($urandom_range(0, 3) << CIU_W);
        cfg_write(REG_CHANNELS_IN_USE, d);
        cfg_write(REG_WINDOW_LEN, CFG_DATA_W'(wlen));
        if (spare)
        begin
            cfg_write(REG_UNUSED_2, CFG_DATA_W'($urandom_range(0, 127)));
            cfg_write(REG_UNUSED_3, CFG_DATA_W'($urandom_range(0, 127)));
        end
        cfg_valid <= 1'b0;
        eff_chans = (chans % 32 > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chans % 32;
    endtask

    // reset, directed words, random phases, verdict
    initial
    begin : stimulus
        int p;
        int k;
        int chans;
        int wlen;
        logic [REQ_W-1:0] req;
        logic [CHAN_W-1:0] ch;
        logic [SMP_W-1:0] smp;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_on     = 1'b1;
        holds_asked = 0;
        eff_chans   = CIU_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: seeds, pushes, rejected channels, all-ones patterns
        send_word(REQ_SEED, 8'd0, SMP_W'(SMP_MAX));
        send_word(REQ_PUSH, 8'd0, '0);
        send_word(REQ_PUSH, 8'd15, SMP_W'(SMP_MAX));
        send_word(REQ_PUSH, 8'd16, SMP_W'(5));
        send_word(REQ_PUSH, 8'd255, SMP_W'(SMP_MAX));
        send_word(REQ_SEED, 8'd3, '0);
        send_word(REQ_PUSH, 8'd3, 10'h2AA);
        send_word(REQ_PUSH, 8'd3, 10'h155);
        send_word(REQ_SEED, 8'd255, '0);
        for (k = 0; k < 6; k++)
            send_word(REQ_PUSH, 8'd2, SMP_W'($urandom_range(0, SMP_MAX)));
        drain();

        // shorter window leaves channel 2 pointer stale
        apply_config(16, 3, 1'b0);
        send_word(REQ_PUSH, 8'd2, SMP_W'(512));
        send_word(REQ_PUSH, 8'd0, SMP_W'($urandom_range(0, SMP_MAX)));
        drain();

        // zero channels rejects everything, zero length acts as one
        apply_config(0, 0, 1'b1);
        send_word(REQ_PUSH, 8'd0, SMP_W'($urandom_range(0, SMP_MAX)));
        drain();

        // oversized settings clamp to the maximum
        apply_config(31, 127, 1'b0);
        send_word(REQ_SEED, 8'd0, SMP_W'(SMP_MAX));
        drain();

        // full-window sum over length one saturates the average
        apply_config(1, 0, 1'b0);
        send_word(REQ_PUSH, 8'd0, SMP_W'(SMP_MAX));
        send_word(REQ_SEED, 8'd0, '0);
        send_word(REQ_PUSH, 8'd1, SMP_W'($urandom_range(0, SMP_MAX)));
        drain();

        // stale large slot drives the sum below zero
        apply_config(16, 2, 1'b0);
        send_word(REQ_PUSH, 8'd0, SMP_W'(5));
        send_word(REQ_PUSH, 8'd0, '0);
        drain();

        // random phases under changing settings
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
            begin
                chans = DEF_MAX_CHANNELS;
                wlen  = DEF_MAX_WINDOW;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       chans = 0;
                    1:       chans = $urandom_range(17, 31);
                    default: chans = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 9))
                    0:       wlen = 0;
                    1:       wlen = $urandom_range(65, 127);
                    2:       wlen = $urandom_range(17, 64);
                    default: wlen = $urandom_range(1, 12);
                endcase
            end
            apply_config(chans, wlen, p == 3);
            idle_on = !(p == 5 || p == NUM_PHASES - 1);
            if (p == 1)
                holds_asked++;

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                req = ($urandom_range(0, 6) == 0) ? REQ_SEED : REQ_PUSH;
                if (eff_chans > 0 && $urandom_range(0, 4) != 0)
                    ch = CHAN_W'($urandom_range(0, eff_chans - 1));
                else
                    ch = CHAN_W'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0:       smp = '0;
                    1:       smp = SMP_W'(SMP_MAX);
                    default: smp = SMP_W'($urandom_range(0, SMP_MAX));
                endcase
                send_word(req, ch, smp);
            end
            drain();
        end

        // let any stray word show up before the verdict
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mma_pkg.sv
design/mma_div.sv
design/mma_dp.sv
design/mma_ctrl.sv
design/multichannel_moving_average.sv
bench/moving_average_checker.sv
bench/tb.sv
